### rtl/sha_pkg.sv
// Shared types, constants and round tables for the SHA-256 byte stream hasher.
`default_nettype none
package sha_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;

    // One queued message item after front-end filtering.
    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       last;
    } sha_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_UPDATE,
        ST_PAD,
        ST_OUT
    } sha_state_t;

    typedef enum logic [1:0] {
        PAD_MARK,
        PAD_ZERO,
        PAD_LEN
    } sha_pad_t;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    // Round constants.
    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k;
        unique case (idx)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    // Initial hash values.
    function automatic logic [31:0] init_hash(input logic [2:0] idx);
        logic [31:0] h;
        unique case (idx)
            3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab; 3'd7: h = 32'h5be0cd19;
            default: h = 32'h0;
        endcase
        return h;
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage
`default_nettype wire

### rtl/sha256_byte_stream_hasher.sv
// SHA-256 over a byte stream: top level joining front end, queue and engine.
//
// Each message byte is stored in the block buffer; every 64th byte starts a compression
// of 64 rounds plus a chaining update, all done by a single round unit. The end mark
// starts the padding, written byte by byte through the length field, then one or two
// further compressions, and eight digest transfers follow. A short queue in front of
// the engine takes bytes, until it is full, while the engine compresses or waits on
// the output.
`default_nettype none
module sha256_byte_stream_hasher #(
    parameter int unsigned QueueDepth = sha_pkg::QUEUE_DEPTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] message_byte
    input  wire logic        s_tuser,   // [0] byte_present
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [31:0] digest_word, [34:32] word_number
    output logic             m_tlast
);

    sha_pkg::sha_item_t push_item, pop_item;
    logic push, pop, full, empty;

    sha_front u_front
    (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_full   (full),
        .q_push   (push),
        .q_item   (push_item)
    );

    sha_queue #(.Depth(QueueDepth)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (empty)
    );

    sha_engine u_engine
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (empty),
        .q_item   (pop_item),
        .q_pop    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire

### rtl/sha_front.sv
// Input side: accepts stream transfers and forwards only items that carry work.
`default_nettype none
module sha_front
(
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [7:0]        s_tdata,
    input  wire logic              s_tuser,
    input  wire logic              s_tlast,
    input  wire logic              q_full,
    output logic                   q_push,
    output sha_pkg::sha_item_t     q_item
);

    // An item with neither a byte nor an end mark changes nothing and is dropped.
    assign s_tready     = !q_full;
    assign q_push       = s_tvalid && !q_full && (s_tuser || s_tlast);
    assign q_item.data    = s_tdata;
    assign q_item.present = s_tuser;
    assign q_item.last    = s_tlast;

endmodule
`default_nettype wire

### rtl/sha_queue.sv
// Short first-in first-out queue between the front end and the hashing engine.
`default_nettype none
module sha_queue #(
    parameter int unsigned Depth = sha_pkg::QUEUE_DEPTH
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire sha_pkg::sha_item_t push_item,
    output logic                    full,
    input  wire logic               pop,
    output sha_pkg::sha_item_t      pop_item,
    output logic                    empty
);

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);

    sha_pkg::sha_item_t slot_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [CntW-1:0] count_reg;

    assign full     = (count_reg == CntW'(Depth));
    assign empty    = (count_reg == '0);
    assign pop_item = slot_reg[rd_ptr_reg];

    // Storage is payload only.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

### rtl/sha_engine.sv
// Back end: block assembly, padding, 64-round compression and digest output.
`default_nettype none
module sha_engine
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_empty,
    input  wire sha_pkg::sha_item_t q_item,
    output logic                    q_pop,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [39:0]             m_tdata,
    output logic                    m_tlast
);

    sha_pkg::sha_state_t state_reg, state_next;
    sha_pkg::sha_pad_t   pad_reg, pad_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic [2:0]  widx_reg, widx_next;
    logic [63:0] bits_reg, bits_next;
    logic        endp_reg, endp_next;
    logic        padding_reg, padding_next;
    logic        final_reg, final_next;
    logic        hash_init;

    logic [31:0] hash_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];

    logic        wr_en;
    logic [7:0]  wr_byte;
    logic        start_cmp;
    logic        do_round;
    logic        do_update;
    logic [5:0]  len_shift;
    logic [7:0]  len_byte;

    // Round datapath.
    logic [31:0] big0, big1, ch, maj, t1, t2, sig0, sig1, w_new;

    always_comb
    begin
        big1  = sha_pkg::rotr(v_reg[4], 6) ^ sha_pkg::rotr(v_reg[4], 11)
              ^ sha_pkg::rotr(v_reg[4], 25);
        ch    = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1    = v_reg[7] + big1 + ch + sha_pkg::round_k(rnd_reg) + w_reg[0];
        big0  = sha_pkg::rotr(v_reg[0], 2) ^ sha_pkg::rotr(v_reg[0], 13)
              ^ sha_pkg::rotr(v_reg[0], 22);
        maj   = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2    = big0 + maj;
        sig0  = sha_pkg::rotr(w_reg[1], 7) ^ sha_pkg::rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        sig1  = sha_pkg::rotr(w_reg[14], 17) ^ sha_pkg::rotr(w_reg[14], 19)
              ^ (w_reg[14] >> 10);
        w_new = sig1 + w_reg[9] + sig0 + w_reg[0];
    end

    // Length bytes go out most significant first at positions 56 to 63.
    assign len_shift = {~cnt_reg[2:0], 3'b000};
    assign len_byte  = 8'(bits_reg >> len_shift);

    // Control sequencer.
    always_comb
    begin
        state_next   = state_reg;
        pad_next     = pad_reg;
        cnt_next     = cnt_reg;
        rnd_next     = rnd_reg;
        widx_next    = widx_reg;
        bits_next    = bits_reg;
        endp_next    = endp_reg;
        padding_next = padding_reg;
        final_next   = final_reg;
        q_pop        = 1'b0;
        wr_en        = 1'b0;
        wr_byte      = q_item.data;
        start_cmp    = 1'b0;
        do_round     = 1'b0;
        do_update    = 1'b0;
        hash_init    = 1'b0;
        unique case (state_reg)
            sha_pkg::ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    if (q_item.present)
                    begin
                        wr_en     = 1'b1;
                        cnt_next  = cnt_reg + 1'b1;
                        bits_next = bits_reg + 64'd8;
                        if (cnt_reg == 6'd63)
                        begin
                            start_cmp  = 1'b1;
                            endp_next  = q_item.last;
                            state_next = sha_pkg::ST_ROUND;
                        end
                        else if (q_item.last)
                        begin
                            pad_next   = sha_pkg::PAD_MARK;
                            state_next = sha_pkg::ST_PAD;
                        end
                    end
                    else
                    begin
                        pad_next   = sha_pkg::PAD_MARK;
                        state_next = sha_pkg::ST_PAD;
                    end
                end
            end
            sha_pkg::ST_ROUND:
            begin
                do_round = 1'b1;
                rnd_next = rnd_reg + 1'b1;
                if (rnd_reg == 6'd63)
                begin
                    state_next = sha_pkg::ST_UPDATE;
                end
            end
            sha_pkg::ST_UPDATE:
            begin
                do_update = 1'b1;
                if (final_reg)
                begin
                    widx_next  = '0;
                    state_next = sha_pkg::ST_OUT;
                end
                else if (padding_reg)
                begin
                    state_next = sha_pkg::ST_PAD;
                end
                else if (endp_reg)
                begin
                    endp_next  = 1'b0;
                    pad_next   = sha_pkg::PAD_MARK;
                    state_next = sha_pkg::ST_PAD;
                end
                else
                begin
                    state_next = sha_pkg::ST_IDLE;
                end
            end
            sha_pkg::ST_PAD:
            begin
                padding_next = 1'b1;
                unique case (pad_reg)
                    sha_pkg::PAD_MARK:
                    begin
                        wr_en    = 1'b1;
                        wr_byte  = sha_pkg::PAD_BYTE;
                        pad_next = sha_pkg::PAD_ZERO;
                    end
                    sha_pkg::PAD_ZERO:
                    begin
                        if (cnt_reg == sha_pkg::LEN_POS)
                        begin
                            pad_next = sha_pkg::PAD_LEN;
                        end
                        else
                        begin
                            wr_en   = 1'b1;
                            wr_byte = 8'h00;
                        end
                    end
                    sha_pkg::PAD_LEN:
                    begin
                        wr_en   = 1'b1;
                        wr_byte = len_byte;
                        if (cnt_reg == 6'd63)
                        begin
                            final_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        pad_next = sha_pkg::PAD_MARK;
                    end
                endcase
                if (wr_en)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == 6'd63)
                    begin
                        start_cmp  = 1'b1;
                        state_next = sha_pkg::ST_ROUND;
                    end
                end
            end
            sha_pkg::ST_OUT:
            begin
                if (m_tready)
                begin
                    widx_next = widx_reg + 1'b1;
                    if (widx_reg == 3'd7)
                    begin
                        hash_init    = 1'b1;
                        bits_next    = '0;
                        cnt_next     = '0;
                        padding_next = 1'b0;
                        final_next   = 1'b0;
                        endp_next    = 1'b0;
                        state_next   = sha_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = sha_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= sha_pkg::ST_IDLE;
            pad_reg     <= sha_pkg::PAD_MARK;
            cnt_reg     <= '0;
            rnd_reg     <= '0;
            widx_reg    <= '0;
            bits_reg    <= '0;
            endp_reg    <= 1'b0;
            padding_reg <= 1'b0;
            final_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pad_reg     <= pad_next;
            cnt_reg     <= cnt_next;
            rnd_reg     <= rnd_next;
            widx_reg    <= widx_next;
            bits_reg    <= bits_next;
            endp_reg    <= endp_next;
            padding_reg <= padding_next;
            final_reg   <= final_next;
        end
    end

    // Chaining value: reset to the initial values, reloaded with them after each digest, updated after each block.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= sha_pkg::init_hash(3'(i));
            end
        end
        else if (hash_init)
        begin
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= sha_pkg::init_hash(3'(i));
            end
        end
        else if (do_update)
        begin
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= hash_reg[i] + v_reg[i];
            end
        end
    end

    // Working variables, one round per cycle.
    always_ff @(posedge clk)
    begin
        if (start_cmp)
        begin
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= hash_reg[i];
            end
        end
        else if (do_round)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    // Block buffer doubles as the sliding message schedule window.
    always_ff @(posedge clk)
    begin
        if (do_round)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= w_new;
        end
        else if (wr_en)
        begin
            w_reg[cnt_reg[5:2]][{~cnt_reg[1:0], 3'b000} +: 8] <= wr_byte;
        end
    end

    // Digest words are shown straight from the chaining registers.
    assign m_tvalid = (state_reg == sha_pkg::ST_OUT);
    assign m_tdata  = {5'b00000, widx_reg, hash_reg[widx_reg]};
    assign m_tlast  = (widx_reg == 3'd7);

endmodule
`default_nettype wire

### rtl/sha_checker.sv
// Port-level checks on the digest output of the hasher, with their bind.
`default_nettype none
module sha_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata,
    input wire logic        m_tlast
);

    // The final word of a digest is always word seven.
    a_last_is_seven: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tdata[34:32] == 3'd7)))
        else $error("tlast does not match word seven");

    // Within a digest the next word follows at once.
    a_digest_unbroken: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
        else $error("digest interrupted");

    // Word numbers rise by one across a digest.
    a_word_order: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=>
            (m_tdata[34:32] == $past(m_tdata[34:32]) + 3'd1))
        else $error("digest word out of order");

    // A stalled transfer holds its data.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("output changed while stalled");

endmodule

bind sha256_byte_stream_hasher sha_checker u_sha_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
`default_nettype wire
